/* hw/rtl/pcxrle_pkg.sv */
package pcxrle_pkg;

    localparam int MAX_WIDTH       = 4096;
    localparam int MAX_HEIGHT      = 4096;
    localparam int PALETTE_ENTRIES = 256;

    localparam int CFG_AW   = 5;
    localparam int CFG_DW   = 32;
    localparam int WIDTH_W  = 13;
    localparam int HEIGHT_W = 13;
    localparam int BPL_W    = 16;
    localparam int LIM_W    = 17;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 12;
    localparam int ROWCNT_W = 13;
    localparam int RUN_W    = 6;
    localparam int PIDX_W   = $clog2(PALETTE_ENTRIES);
    localparam int OUT_DW   = 40;

    localparam logic [7:0]       RUN_FLAG    = 8'hC0;
    localparam logic [7:0]       PAL_MARKER  = 8'd12;
    localparam logic [1:0]       LAST_COMP   = 2'd2;
    localparam logic [PIDX_W-1:0] LAST_PIDX  = PIDX_W'(PALETTE_ENTRIES - 1);

    typedef enum logic [2:0] {
        REG_RGB_MODE     = 3'd0,
        REG_RLE_ENCODED  = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3,
        REG_BYTES_PER_LN = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_PIXEL      = 2'd0,
        ST_PALETTE    = 2'd1,
        ST_NO_MARKER  = 2'd2,
        ST_COMPLETE   = 2'd3
    } status_t;

    typedef struct packed {
        logic                rgb_mode;
        logic                rle_encoded;
        logic [WIDTH_W-1:0]  image_width;
        logic [HEIGHT_W-1:0] image_height;
        logic [BPL_W-1:0]    line_pitch;
    } cfg_t;

    typedef struct packed {
        logic take;
        logic step;
        logic cmpl;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic more;
        logic cmpl;
    } dp_stat_t;

endpackage

/* hw/rtl/pcxrle_cfg_regs.sv */
module pcxrle_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pcxrle_pkg::CFG_AW-1:0]    paddr,
    input  logic [pcxrle_pkg::CFG_DW-1:0]    pwdata,
    output logic [pcxrle_pkg::CFG_DW-1:0]    prdata,
    output logic                             pready,
    output pcxrle_pkg::cfg_t                 cfg
);
    import pcxrle_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rgb_mode     <= 1'b0;
            cfg_reg.rle_encoded  <= 1'b1;
            cfg_reg.image_width  <= WIDTH_W'(1);
            cfg_reg.image_height <= HEIGHT_W'(1);
            cfg_reg.line_pitch   <= BPL_W'(1);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_RGB_MODE:     cfg_reg.rgb_mode     <= pwdata[0];
                REG_RLE_ENCODED:  cfg_reg.rle_encoded  <= pwdata[0];
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[HEIGHT_W-1:0];
                REG_BYTES_PER_LN: cfg_reg.line_pitch   <= pwdata[BPL_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_RGB_MODE:     prdata = CFG_DW'(cfg_reg.rgb_mode);
            REG_RLE_ENCODED:  prdata = CFG_DW'(cfg_reg.rle_encoded);
            REG_IMAGE_WIDTH:  prdata = CFG_DW'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = CFG_DW'(cfg_reg.image_height);
            REG_BYTES_PER_LN: prdata = CFG_DW'(cfg_reg.line_pitch);
            default:          prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/pcxrle_ctrl.sv */
module pcxrle_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  pcxrle_pkg::dp_stat_t  stat,
    output pcxrle_pkg::dp_cmd_t   cmd
);
    import pcxrle_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_CMPL
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE) && stat.out_free;
    assign cmd.take = s_tvalid && s_tready;
    assign cmd.step = (state_reg == S_RUN) && stat.out_free;
    assign cmd.cmpl = (state_reg == S_CMPL) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.take)
                begin
                    if (stat.more)
                        state_next = S_RUN;
                    else if (stat.cmpl)
                        state_next = S_CMPL;
                end
            end
            S_RUN:
            begin
                if (cmd.step && !stat.more)
                    state_next = stat.cmpl ? S_CMPL : S_IDLE;
            end
            S_CMPL:
            begin
                if (cmd.cmpl)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef NO_ASSERTIONS
    a_run_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && cmd.take && stat.more) |=> (state_reg == S_RUN))
        else $error("run not entered after multi-byte step");
`endif

endmodule

/* hw/rtl/pcxrle_datapath.sv */
module pcxrle_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pcxrle_pkg::cfg_t                   cfg,
    input  pcxrle_pkg::dp_cmd_t                cmd,
    output pcxrle_pkg::dp_stat_t               stat,
    input  logic                               begin_image,
    input  logic [7:0]                         data_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output pcxrle_pkg::status_t                out_status,
    output logic [7:0]                         out_value,
    output logic [pcxrle_pkg::ROW_W-1:0]       out_row,
    output logic [pcxrle_pkg::COL_W-1:0]       out_column,
    output logic [1:0]                         out_component,
    output logic                               out_last
);
    import pcxrle_pkg::*;

    typedef enum logic [1:0] {
        PH_PIXELS,
        PH_MARKER,
        PH_PALETTE,
        PH_DONE
    } phase_t;

    phase_t              phase_reg, phase_next, cur_phase;
    logic                pend_reg, pend_next, cur_pend;
    logic [RUN_W-1:0]    len_reg, len_next, cur_len;
    logic [BPL_W-1:0]    col_reg, col_next, cur_col;
    logic [1:0]          plane_reg, plane_next, cur_plane;
    logic [ROWCNT_W-1:0] row_reg, row_next, cur_row;
    logic [PIDX_W-1:0]   pidx_reg, pidx_next, cur_pidx;
    logic [1:0]          pcomp_reg, pcomp_next, cur_pcomp;
    logic [RUN_W-1:0]    rem_reg, rem_next;
    logic [7:0]          val_reg, val_next;

    logic                valid_reg;
    status_t             status_reg, status_next;
    logic [7:0]          value_reg, value_next;
    logic [ROW_W-1:0]    orow_reg, orow_next;
    logic [COL_W-1:0]    ocol_reg, ocol_next;
    logic [1:0]          ocomp_reg, ocomp_next;
    logic                last_reg, last_next;
    logic                load;

    logic                clr, is_hdr, do_step, emit_px, wrap, line_end, img_end;
    logic                more, next_emit, cmpl_px, pal_end, last_row;
    logic [LIM_W-1:0]    width_eff, height_eff, bpl_eff, col1, reach;
    logic [ROWCNT_W:0]   row1;
    logic [1:0]          plane1, planes;
    logic [7:0]          it_val;
    logic [RUN_W-1:0]    it_rem, rem_after;

    always_comb
    begin
        width_eff  = (LIM_W'(cfg.image_width) > LIM_W'(MAX_WIDTH)) ?
                     LIM_W'(MAX_WIDTH) : LIM_W'(cfg.image_width);
        height_eff = (cfg.image_height == '0) ? LIM_W'(1) :
                     ((LIM_W'(cfg.image_height) > LIM_W'(MAX_HEIGHT)) ?
                      LIM_W'(MAX_HEIGHT) : LIM_W'(cfg.image_height));
        bpl_eff    = (cfg.line_pitch == '0) ? LIM_W'(1) : LIM_W'(cfg.line_pitch);
        planes     = cfg.rgb_mode ? 2'd3 : 2'd1;

        clr       = cmd.take && begin_image;
        cur_phase = clr ? PH_PIXELS : phase_reg;
        cur_pend  = clr ? 1'b0 : pend_reg;
        cur_len   = clr ? '0 : len_reg;
        cur_col   = clr ? '0 : col_reg;
        cur_plane = clr ? '0 : plane_reg;
        cur_row   = clr ? '0 : row_reg;
        cur_pidx  = clr ? '0 : pidx_reg;
        cur_pcomp = clr ? '0 : pcomp_reg;

        it_val  = cmd.step ? val_reg : data_byte;
        it_rem  = cmd.step ? rem_reg : (cur_pend ? cur_len : RUN_W'(1));
        is_hdr  = !cur_pend && cfg.rle_encoded && ((data_byte & RUN_FLAG) == RUN_FLAG);
        do_step = cmd.step ||
                  (cmd.take && cur_phase == PH_PIXELS && !is_hdr && it_rem != '0);

        emit_px   = LIM_W'(cur_col) < width_eff;
        col1      = LIM_W'(cur_col) + LIM_W'(1);
        wrap      = col1 >= bpl_eff;
        plane1    = cur_plane + 2'd1;
        line_end  = wrap && (plane1 >= planes);
        row1      = (ROWCNT_W+1)'(cur_row) + (ROWCNT_W+1)'(1);
        last_row  = LIM_W'(row1) >= height_eff;
        img_end   = line_end && last_row;
        more      = !line_end && (it_rem > RUN_W'(1));
        rem_after = it_rem - RUN_W'(1);
        // does a later step of this run give a pixel or the completion beat
        reach     = col1 + LIM_W'(rem_after);
        next_emit = more && (wrap || (col1 < width_eff) ||
                    ((plane1 < planes) ? (reach > bpl_eff)
                                       : ((reach >= bpl_eff) && last_row && cfg.rgb_mode)));
        cmpl_px   = img_end && cfg.rgb_mode;
        pal_end   = (cur_pidx == LAST_PIDX) && (cur_pcomp == LAST_COMP);

        phase_next = cur_phase;
        pend_next  = cur_pend;
        len_next   = cur_len;
        col_next   = cur_col;
        plane_next = cur_plane;
        row_next   = cur_row;
        pidx_next  = cur_pidx;
        pcomp_next = cur_pcomp;
        rem_next   = rem_reg;
        val_next   = val_reg;

        load        = 1'b0;
        status_next = ST_PIXEL;
        value_next  = '0;
        orow_next   = '0;
        ocol_next   = '0;
        ocomp_next  = '0;
        last_next   = 1'b1;

        if (cmd.take && cur_phase == PH_PIXELS)
        begin
            if (cur_pend)
                pend_next = 1'b0;
            else if (is_hdr)
            begin
                pend_next = 1'b1;
                len_next  = data_byte[RUN_W-1:0];
            end
        end

        if (do_step)
        begin
            val_next = it_val;
            rem_next = rem_after;
            col_next = wrap ? '0 : col1[BPL_W-1:0];
            if (wrap)
                plane_next = line_end ? 2'd0 : plane1;
            if (line_end)
                row_next = row1[ROWCNT_W-1:0];
            if (img_end)
                phase_next = cfg.rgb_mode ? PH_DONE : PH_MARKER;
            if (emit_px)
            begin
                load        = 1'b1;
                status_next = ST_PIXEL;
                value_next  = it_val;
                orow_next   = cur_row[ROW_W-1:0];
                ocol_next   = cur_col[COL_W-1:0];
                ocomp_next  = cur_plane;
                last_next   = !next_emit && !cmpl_px;
            end
        end

        if (cmd.take && cur_phase == PH_MARKER)
        begin
            if (data_byte == PAL_MARKER)
            begin
                phase_next = PH_PALETTE;
                pidx_next  = '0;
                pcomp_next = '0;
            end
            else
            begin
                phase_next  = PH_DONE;
                load        = 1'b1;
                status_next = ST_NO_MARKER;
            end
        end

        if (cmd.take && cur_phase == PH_PALETTE)
        begin
            load        = 1'b1;
            status_next = ST_PALETTE;
            value_next  = data_byte;
            ocol_next   = COL_W'(cur_pidx);
            ocomp_next  = cur_pcomp;
            last_next   = !pal_end;
            if (cur_pcomp == LAST_COMP)
            begin
                pcomp_next = '0;
                pidx_next  = cur_pidx + PIDX_W'(1);
            end
            else
                pcomp_next = cur_pcomp + 2'd1;
            if (pal_end)
                phase_next = PH_DONE;
        end

        if (cmd.cmpl)
        begin
            load        = 1'b1;
            status_next = ST_COMPLETE;
        end

        stat.out_free = !valid_reg || out_ready;
        stat.more     = do_step && more;
        stat.cmpl     = (do_step && cmpl_px) ||
                        (cmd.take && cur_phase == PH_PALETTE && pal_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PIXELS;
            pend_reg  <= 1'b0;
            len_reg   <= '0;
            col_reg   <= '0;
            plane_reg <= '0;
            row_reg   <= '0;
            pidx_reg  <= '0;
            pcomp_reg <= '0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            len_reg   <= len_next;
            col_reg   <= col_next;
            plane_reg <= plane_next;
            row_reg   <= row_next;
            pidx_reg  <= pidx_next;
            pcomp_reg <= pcomp_next;
            rem_reg   <= rem_next;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (load)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            orow_reg   <= orow_next;
            ocol_reg   <= ocol_next;
            ocomp_reg  <= ocomp_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_status    = status_reg;
    assign out_value     = value_reg;
    assign out_row       = orow_reg;
    assign out_column    = ocol_reg;
    assign out_component = ocomp_reg;
    assign out_last      = last_reg;

`ifndef NO_ASSERTIONS
    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        plane_reg != 2'd3)
        else $error("plane counter out of range");

    a_pcomp_range: assert property (@(posedge clk) disable iff (!rst_n)
        pcomp_reg != 2'd3)
        else $error("palette component out of range");

    a_pend_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (phase_reg == PH_PIXELS))
        else $error("run pending outside pixel phase");
`endif

endmodule

/* hw/rtl/pcx_rle_scanline_decoder_unit.sv */
// Channel   Dir  Beat contents
// s_*       in   tuser: begin_image; tdata[7:0]: data_byte
// m_*       out  tuser: status; tdata: value, row, column, component; tlast: last_of_run
// apb       in   five config registers at 4*i, pready always high
//
// Literal byte, run header, marker and palette byte: each is done on its accept.
// A run value byte with count n steps through n positions (fewer when the line ends first),
// s_tready staying low after the accept until the run is done; a zero count steps nothing.
// A trailing completion beat is sent with s_tready low. Dropped bytes of a run still step.
// Any cycle also waits while the output register is full and m_tready is low.
// Asynchronous active-low reset; the config registers take their reset values.
module pcx_rle_scanline_decoder_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // data_byte
    input  logic                             s_tuser,   // begin_image
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pcxrle_pkg::OUT_DW-1:0]    m_tdata,   // value, row, column, component
    output logic [1:0]                       m_tuser,   // status
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pcxrle_pkg::CFG_AW-1:0]    paddr,
    input  logic [pcxrle_pkg::CFG_DW-1:0]    pwdata,
    output logic [pcxrle_pkg::CFG_DW-1:0]    prdata,
    output logic                             pready
);
    import pcxrle_pkg::*;

    cfg_t             cfg;
    dp_cmd_t          cmd;
    dp_stat_t         stat;
    status_t          out_status;
    logic [7:0]       out_value;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_column;
    logic [1:0]       out_component;

    pcxrle_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcxrle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pcxrle_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .begin_image   (s_tuser),
        .data_byte     (s_tdata),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_status    (out_status),
        .out_value     (out_value),
        .out_row       (out_row),
        .out_column    (out_column),
        .out_component (out_component),
        .out_last      (m_tlast)
    );

    assign m_tuser = out_status;
    assign m_tdata = {(OUT_DW - 8 - ROW_W - COL_W - 2)'(0),
                      out_component, out_column, out_row, out_value};

endmodule

/* test/pcx_rle_scanline_decoder_unit_test.sv */
`timescale 1ns / 1ps

module pcx_rle_scanline_decoder_unit_test;

    import pcxrle_pkg::*;

    typedef enum logic [1:0] {PH_PIXELS, PH_MARKER, PH_PALETTE, PH_DONE} dec_phase_t;
    typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} rdy_mode_e;
    typedef enum {PR_TYPICAL, PR_NO_WIDTH, PR_NO_BPL, PR_WIDE, PR_TALL} profile_e;

    typedef struct packed {
        status_t     st;
        logic [7:0]  val;
        logic [11:0] row;
        logic [11:0] col;
        logic [1:0]  comp;
        logic        last;
    } pix_result_t;

    typedef struct {
        bit          is_cfg;
        reg_idx_t    idx;
        logic        begin_img;
        logic [31:0] data;
        int          typed_n;
        pix_result_t want;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    pcx_rle_scanline_decoder_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // decoder mirror: configuration and position state
    logic               cfg_rgb = 1'b0;
    logic               cfg_rle = 1'b1;
    logic [WIDTH_W-1:0] cfg_width = 1;
    logic [HEIGHT_W-1:0] cfg_height = 1;
    logic [BPL_W-1:0]   cfg_bpl = 1;

    dec_phase_t dec_ph = PH_PIXELS;
    logic       run_pend = 1'b0;
    logic [5:0] run_len = '0;
    int         col_cnt = 0;
    int         plane_cnt = 0;
    int         row_cnt = 0;
    int         pal_cnt = 0;

    pix_result_t step_res[$];
    pix_result_t pixel_q[$];
    dir_row_t    dir_tbl[$];

    int errors = 0;
    int n_handled = 0;
    int n_results = 0;
    int n_images = 0;
    int n_phases = 0;
    int n_by_status[4] = '{0, 0, 0, 0};
    int burst_left = 0;
    logic next_begin = 1'b0;

    rdy_mode_e  rdy_mode = RDY_ALWAYS;
    int         rdy_left = 0;
    logic [7:0] rdy_pat = 8'hFF;

    function automatic pix_result_t mk(status_t st, logic [7:0] v, int r, int c, int cp);
        pix_result_t p;
        p.st = st;
        p.val = v;
        p.row = 12'(r);
        p.col = 12'(c);
        p.comp = 2'(cp);
        p.last = 1'b0;
        return p;
    endfunction

    function automatic void decode_byte(logic bi, logic [7:0] b);
        int planes;
        int bpl;
        int wid;
        int hgt;
        int count;
        logic [7:0] v;
        step_res.delete();
        if (bi)
        begin
            dec_ph = PH_PIXELS;
            run_pend = 1'b0;
            run_len = '0;
            col_cnt = 0;
            plane_cnt = 0;
            row_cnt = 0;
            pal_cnt = 0;
        end
        case (dec_ph)
            PH_PIXELS:
            begin
                planes = cfg_rgb ? 3 : 1;
                bpl = (cfg_bpl == 0) ? 1 : int'(cfg_bpl);
                wid = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
                hgt = (cfg_height == 0) ? 1 : int'(cfg_height);
                if (hgt > MAX_HEIGHT)
                    hgt = MAX_HEIGHT;
                count = 0;
                v = b;
                if (run_pend)
                begin
                    count = int'(run_len);
                    run_pend = 1'b0;
                end
                else if (cfg_rle && (b & RUN_FLAG) == RUN_FLAG)
                begin
                    run_pend = 1'b1;
                    run_len = b[5:0];
                end
                else
                    count = 1;
                for (int i = 0; i < count; i++)
                begin
                    if (col_cnt < wid)
                        step_res.push_back(mk(ST_PIXEL, v, row_cnt, col_cnt, plane_cnt));
                    col_cnt++;
                    if (col_cnt >= bpl)
                    begin
                        col_cnt = 0;
                        plane_cnt++;
                        if (plane_cnt >= planes)
                        begin
                            plane_cnt = 0;
                            row_cnt++;
                            if (row_cnt >= hgt)
                            begin
                                if (cfg_rgb)
                                begin
                                    step_res.push_back(mk(ST_COMPLETE, 8'h00, 0, 0, 0));
                                    dec_ph = PH_DONE;
                                end
                                else
                                    dec_ph = PH_MARKER;
                            end
                            // rest of the run is dropped at line end
                            break;
                        end
                    end
                end
            end
            PH_MARKER:
            begin
                if (b == PAL_MARKER)
                begin
                    dec_ph = PH_PALETTE;
                    pal_cnt = 0;
                end
                else
                begin
                    step_res.push_back(mk(ST_NO_MARKER, 8'h00, 0, 0, 0));
                    dec_ph = PH_DONE;
                end
            end
            PH_PALETTE:
            begin
                step_res.push_back(mk(ST_PALETTE, b, 0, pal_cnt / 3, pal_cnt % 3));
                pal_cnt++;
                if (pal_cnt >= 3 * PALETTE_ENTRIES)
                begin
                    step_res.push_back(mk(ST_COMPLETE, 8'h00, 0, 0, 0));
                    dec_ph = PH_DONE;
                end
            end
            default: ;
        endcase
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_beat(logic bi, logic [7:0] d, int tn, pix_result_t w);
        dir_row_t r;
        r.is_cfg = 1'b0;
        r.idx = REG_RGB_MODE;
        r.begin_img = bi;
        r.data = 32'(d);
        r.typed_n = tn;
        r.want = w;
        r.want.last = 1'b1;
        dir_tbl.push_back(r);
    endfunction

    function automatic void add_cfg(reg_idx_t idx, logic [31:0] v);
        dir_row_t r;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.begin_img = 1'b0;
        r.data = v;
        r.typed_n = 0;
        r.want = '0;
        dir_tbl.push_back(r);
    endfunction

    task automatic chk(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // the idle wait covers a fully dropped 63-byte run plus the output register
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pixel_q.size() > 0)
            @(posedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        wait_idle();
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = CFG_AW'({idx, 2'b00});
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_RGB_MODE:     cfg_rgb = v[0];
            REG_RLE_ENCODED:  cfg_rle = v[0];
            REG_IMAGE_WIDTH:  cfg_width = v[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: cfg_height = v[HEIGHT_W-1:0];
            REG_BYTES_PER_LN: cfg_bpl = v[BPL_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_config(logic rgb, logic rle, int w, int h, int bpl);
        write_reg(REG_RGB_MODE, 32'(rgb));
        write_reg(REG_RLE_ENCODED, 32'(rle));
        write_reg(REG_IMAGE_WIDTH, 32'(w));
        write_reg(REG_IMAGE_HEIGHT, 32'(h));
        write_reg(REG_BYTES_PER_LN, 32'(bpl));
        n_phases++;
    endtask

    // tn < 0: expectation from the mirror, else tn typed results
    task automatic send_beat(logic bi, logic [7:0] b, int tn, pix_result_t want);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 24);
        end
        s_tvalid = 1'b1;
        s_tuser = bi;
        s_tdata = b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (bi || dec_ph != PH_DONE)
            n_handled++;
        decode_byte(bi, b);
        if (tn < 0)
        begin
            foreach (step_res[i])
                pixel_q.push_back(step_res[i]);
        end
        else if (tn == 1)
            pixel_q.push_back(want);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic stream_byte(logic [7:0] b);
        send_beat(next_begin, b, -1, '0);
        next_begin = 1'b0;
    endtask

    task automatic gen_image(int max_lines, bit full_pal);
        int planes;
        int bpl;
        int hgt;
        int n_lines;
        int remaining;
        int c;
        int r;
        int pal_n;
        logic [7:0] mb;
        planes = cfg_rgb ? 3 : 1;
        bpl = (cfg_bpl == 0) ? 1 : int'(cfg_bpl);
        hgt = (cfg_height == 0) ? 1 : int'(cfg_height);
        if (hgt > MAX_HEIGHT)
            hgt = MAX_HEIGHT;
        n_lines = (hgt < max_lines) ? hgt : max_lines;
        next_begin = 1'b1;
        n_images++;
        for (int ln = 0; ln < n_lines; ln++)
        begin
            remaining = planes * bpl;
            while (remaining > 0)
            begin
                r = $urandom_range(0, 99);
                if (cfg_rle && (remaining > 100 || r < 35))
                begin
                    if (remaining > 100)
                        c = 63;
                    else if (r < 15)
                        c = $urandom_range(0, (remaining < 63) ? remaining : 63);
                    else
                        c = $urandom_range(0, 63);
                    stream_byte(RUN_FLAG | 8'(c));
                    stream_byte(8'($urandom));
                    remaining -= (c > remaining) ? remaining : c;
                end
                else
                begin
                    stream_byte(cfg_rle ? 8'($urandom_range(0, 'hBF)) : 8'($urandom));
                    remaining--;
                end
                if ($urandom_range(0, 99) == 0)
                    stream_byte(8'($urandom));
                if ($urandom_range(0, 299) == 0)
                    next_begin = 1'b1;
            end
        end
        if (!cfg_rgb && n_lines >= hgt)
        begin
            mb = PAL_MARKER;
            if (!full_pal && $urandom_range(0, 7) == 0)
            begin
                mb = 8'($urandom);
                if (mb == PAL_MARKER)
                    mb = 8'hFF;
            end
            stream_byte(mb);
            pal_n = full_pal ? 3 * PALETTE_ENTRIES : $urandom_range(0, 10);
            repeat (pal_n) stream_byte(8'($urandom));
        end
        repeat ($urandom_range(0, 2)) stream_byte(8'($urandom));
    endtask

    always @(negedge clk)
    begin
        if (rdy_left == 0)
        begin
            rdy_mode = rdy_mode_e'($urandom_range(0, 2));
            rdy_left = $urandom_range(20, 200);
            rdy_pat = 8'($urandom) | 8'h11;
        end
        rdy_left--;
        case (rdy_mode)
            RDY_ALWAYS: m_tready = 1'b1;
            RDY_RANDOM: m_tready = ($urandom_range(0, 3) != 0);
            default:
            begin
                m_tready = rdy_pat[0];
                rdy_pat = {rdy_pat[0], rdy_pat[7:1]};
            end
        endcase
    end

    always @(posedge clk)
    begin
        pix_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (!$isunknown(m_tuser))
                n_by_status[m_tuser]++;
            if (pixel_q.size() == 0)
            begin
                $error("result beat with nothing expected, status %0d", m_tuser);
                errors++;
            end
            else
            begin
                e = pixel_q.pop_front();
                chk("status", 32'(e.st), 32'(m_tuser));
                chk("value", 32'(e.val), 32'(m_tdata[7:0]));
                chk("row", 32'(e.row), 32'(m_tdata[19:8]));
                chk("column", 32'(e.col), 32'(m_tdata[31:20]));
                chk("component", 32'(e.comp), 32'(m_tdata[33:32]));
                chk("last_of_run", 32'(e.last), 32'(m_tlast));
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAIL pcx_rle_scanline_decoder_unit");
        $finish;
    end

    initial
    begin
        profile_e prof;
        int       n_img;
        int       max_lines;
        int       wv;
        int       hv;
        int       bv;
        logic     rgbv;
        logic     rlev;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: indexed, RLE, 1x1, one byte per line
        add_beat(1'b1, 8'h00, 1, mk(ST_PIXEL, 8'h00, 0, 0, 0));
        add_beat(1'b0, 8'h05, 1, mk(ST_NO_MARKER, 8'h00, 0, 0, 0));
        add_beat(1'b0, 8'hFF, 0, '0);
        add_beat(1'b1, 8'hC3, 0, '0);
        add_beat(1'b0, 8'hAA, 1, mk(ST_PIXEL, 8'hAA, 0, 0, 0));
        add_beat(1'b0, PAL_MARKER, 0, '0);
        add_beat(1'b0, 8'hFF, 1, mk(ST_PALETTE, 8'hFF, 0, 0, 0));
        add_beat(1'b0, 8'h00, -1, '0);
        add_beat(1'b1, 8'hC0, 0, '0);
        add_beat(1'b0, 8'h55, 0, '0);
        add_beat(1'b0, 8'h3F, -1, '0);
        add_beat(1'b0, PAL_MARKER, -1, '0);
        // RGB, raw, 2 wide, 2 high, 3 bytes per plane
        add_cfg(REG_RGB_MODE, 1);
        add_cfg(REG_RLE_ENCODED, 0);
        add_cfg(REG_IMAGE_WIDTH, 2);
        add_cfg(REG_IMAGE_HEIGHT, 2);
        add_cfg(REG_BYTES_PER_LN, 3);
        add_beat(1'b1, 8'hC1, -1, '0);
        add_beat(1'b0, 8'h80, -1, '0);
        add_beat(1'b0, 8'h01, -1, '0);
        add_cfg(REG_RLE_ENCODED, 1);
        add_beat(1'b0, 8'hC5, -1, '0);
        add_beat(1'b0, 8'h11, -1, '0);
        add_beat(1'b0, 8'hC7, -1, '0);
        add_beat(1'b0, 8'h22, -1, '0);
        // run header pending across a switch to raw
        add_beat(1'b0, 8'hC2, -1, '0);
        add_cfg(REG_RLE_ENCODED, 0);
        add_beat(1'b0, 8'hC4, -1, '0);
        add_cfg(REG_RLE_ENCODED, 1);
        add_beat(1'b0, 8'hFF, -1, '0);
        add_beat(1'b0, 8'h99, -1, '0);

        foreach (dir_tbl[i])
        begin
            if (dir_tbl[i].is_cfg)
                write_reg(dir_tbl[i].idx, dir_tbl[i].data);
            else
                send_beat(dir_tbl[i].begin_img, dir_tbl[i].data[7:0],
                          dir_tbl[i].typed_n, dir_tbl[i].want);
        end

        while (n_handled < 230)
        begin
            wv = $urandom_range(0, 9);
            prof = (wv < 6) ? PR_TYPICAL : profile_e'(wv - 5);
            n_img = $urandom_range(1, 2);
            max_lines = 3;
            rgbv = 1'($urandom_range(0, 1));
            rlev = 1'($urandom_range(0, 1));
            wv = $urandom_range(1, 6);
            hv = $urandom_range(1, 3);
            bv = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : wv + $urandom_range(0, 2);
            case (prof)
                PR_NO_WIDTH:
                begin
                    wv = 0;
                    bv = $urandom_range(1, 4);
                end
                PR_NO_BPL:
                begin
                    bv = 0;
                    hv = 0;
                    wv = $urandom_range(0, 2);
                end
                PR_WIDE:
                begin
                    rgbv = 1'b0;
                    rlev = 1'b1;
                    hv = 1;
                    n_img = 1;
                    wv = ($urandom_range(0, 1) == 0) ? 8191 : MAX_WIDTH;
                    bv = ($urandom_range(0, 3) == 0) ? 65535
                                                     : MAX_WIDTH + $urandom_range(0, 150);
                end
                PR_TALL:
                begin
                    hv = ($urandom_range(0, 1) == 0) ? 8191
                                                     : $urandom_range(MAX_HEIGHT + 1, 8190);
                    wv = $urandom_range(1, 4);
                    bv = $urandom_range(1, 4);
                end
                default: ;
            endcase
            set_config(rgbv, rlev, wv, hv, bv);
            repeat (n_img) gen_image(max_lines, 1'b0);
        end

        // one indexed image carried through the whole palette
        set_config(1'b0, 1'b1, 3, 2, 4);
        gen_image(2, 1'b1);

        wait_idle();
        $display("covered %0d config phases, %0d images, %0d input beats, %0d result beats",
                 n_phases, n_images, n_handled, n_results);
        $display("results by kind: pixel %0d, palette %0d, no marker %0d, complete %0d",
                 n_by_status[ST_PIXEL], n_by_status[ST_PALETTE],
                 n_by_status[ST_NO_MARKER], n_by_status[ST_COMPLETE]);
        if (errors == 0)
            $display("PASS pcx_rle_scanline_decoder_unit");
        else
            $display("FAIL pcx_rle_scanline_decoder_unit");
        $finish;
    end

endmodule
